/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers included by the pixel decoder unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tga_rle_pkg.sv */
// ----------------------------------------------------------------------------
// tga_rle_pkg
// constants and types of the targa image-data decoder
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_TYPE  = 2'd0,
    CFG_HAS_ALPHA   = 2'd1,
    CFG_PIXEL_COUNT = 2'd2
  } cfg_idx_t;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned RepeatW   = 8;

  localparam logic [7:0] RunBias    = 8'd127;
  localparam logic [7:0] AlphaOpaque = 8'd255;

  localparam logic              ImageTypeRst  = 1'b1;
  localparam logic              HasAlphaRst   = 1'b0;
  localparam logic [CountW-1:0] PixelCountRst = 32'd1;

  typedef logic [1:0] slot_t;

endpackage

/* design/tga_rle_pixel_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// targa image-data decoder, raw and run-length packets, one byte per cycle
// ----------------------------------------------------------------------------
// Takes one image-data byte per cycle and emits one result per finished pixel
// or finished run packet (color, first pixel index, pixel count, done flag).
// Each accepted byte updates the decoder state in the same cycle and any
// result lands in a single output register, so results appear in the cycle after
// the byte that completes them. A new byte is taken whenever the output
// register is empty or being drained, giving a sustained rate of one byte per
// cycle; the only stall is a result held by a low out_ready. Output is clipped
// at pixel_count and further bytes are dropped until start_of_image.
`include "assert_macros.svh"

module tga_rle_pixel_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [tga_rle_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tga_rle_pkg::CfgDataW-1:0]  cfg_data,
  // byte stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_start_of_image,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_alpha,
  output logic [tga_rle_pkg::CountW-1:0]    out_start_index,
  output logic [tga_rle_pkg::RepeatW-1:0]   out_repeat_res,
  output logic                              out_image_done
);

  localparam int unsigned CW = tga_rle_pkg::CountW;
  localparam int unsigned RW = tga_rle_pkg::RepeatW;

  // configuration registers
  logic          image_type_r;
  logic          has_alpha_r;
  logic [CW-1:0] pixel_count_r;

  // decoder state
  logic [CW-1:0]          pixels_written_r, pixels_written_nxt;
  logic [RW-1:0]          packet_remaining_r, packet_remaining_nxt;
  logic                   packet_is_run_r, packet_is_run_nxt;
  logic                   expect_header_r, expect_header_nxt;
  tga_rle_pkg::slot_t     byte_slot_r, byte_slot_nxt;
  logic [23:0]            gathered_r, gathered_nxt;
  logic                   finished_r, finished_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             red_r, green_r, blue_r, alpha_r;
  logic [CW-1:0]          start_index_r;
  logic [RW-1:0]          repeat_r;
  logic                   done_r;

  // state after an optional restart
  logic [CW-1:0]          cur_pw;
  logic [RW-1:0]          cur_rem;
  logic                   cur_run, cur_exp, cur_fin;
  tga_rle_pkg::slot_t     cur_slot;
  logic [23:0]            cur_gath;

  logic                   in_fire;
  logic                   active, last_byte, emit;
  logic [7:0]             alpha_val;
  logic [RW-1:0]          want, count;
  logic [CW-1:0]          left;
  logic [CW-1:0]          pw_sum;
  logic                   done_w;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cur_pw   = in_start_of_image ? '0 : pixels_written_r;
    cur_rem  = in_start_of_image ? '0 : packet_remaining_r;
    cur_run  = in_start_of_image ? 1'b0 : packet_is_run_r;
    cur_exp  = in_start_of_image ? 1'b1 : expect_header_r;
    cur_slot = in_start_of_image ? '0 : byte_slot_r;
    cur_gath = in_start_of_image ? '0 : gathered_r;
    cur_fin  = in_start_of_image ? 1'b0 : finished_r;

    pixels_written_nxt   = cur_pw;
    packet_remaining_nxt = cur_rem;
    packet_is_run_nxt    = cur_run;
    expect_header_nxt    = cur_exp;
    byte_slot_nxt        = cur_slot;
    gathered_nxt         = cur_gath;
    finished_nxt         = cur_fin;

    active    = !cur_fin && (cur_pw < pixel_count_r);
    last_byte = (cur_slot == 2'd3) || ((cur_slot == 2'd2) && !has_alpha_r);
    emit      = 1'b0;
    alpha_val = tga_rle_pkg::AlphaOpaque;
    want      = RW'(1);

    priority if (!active) begin
      // image complete or past the end: drop the byte
    end else if (image_type_r && cur_exp) begin
      // packet header
      if (!in_byte_value[7]) begin
        packet_remaining_nxt = {1'b0, in_byte_value[6:0]} + RW'(1);
        packet_is_run_nxt    = 1'b0;
      end else begin
        packet_remaining_nxt = in_byte_value - tga_rle_pkg::RunBias;
        packet_is_run_nxt    = 1'b1;
      end
      expect_header_nxt = 1'b0;
      byte_slot_nxt     = '0;
    end else if (!last_byte) begin
      unique case (cur_slot)
        2'd0:    gathered_nxt[7:0]   = in_byte_value;
        2'd1:    gathered_nxt[15:8]  = in_byte_value;
        default: gathered_nxt[23:16] = in_byte_value;
      endcase
      byte_slot_nxt = cur_slot + 2'd1;
    end else begin
      if (cur_slot == 2'd3) begin
        alpha_val = has_alpha_r ? in_byte_value : tga_rle_pkg::AlphaOpaque;
      end else begin
        gathered_nxt[23:16] = in_byte_value;
      end
      byte_slot_nxt = '0;
      emit          = 1'b1;
      if (image_type_r) begin
        if (cur_run) begin
          expect_header_nxt    = 1'b1;
          want                 = cur_rem;
          packet_remaining_nxt = '0;
        end else begin
          packet_remaining_nxt = (cur_rem != '0) ? cur_rem - RW'(1) : cur_rem;
          if (packet_remaining_nxt == '0) begin
            expect_header_nxt = 1'b1;
          end
        end
      end
    end

    // clip the run at the pixels left
    left   = pixel_count_r - cur_pw;
    count  = (left < CW'(want)) ? left[RW-1:0] : want;
    pw_sum = cur_pw + CW'(count);
    done_w = (pw_sum >= pixel_count_r);
    if (emit) begin
      pixels_written_nxt = pw_sum;
      if (done_w) begin
        finished_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_type_r <= tga_rle_pkg::ImageTypeRst;
      has_alpha_r  <= tga_rle_pkg::HasAlphaRst;
      pixel_count_r <= tga_rle_pkg::PixelCountRst;
    end else if (cfg_we) begin
      unique case (tga_rle_pkg::cfg_idx_t'(cfg_index))
        tga_rle_pkg::CFG_IMAGE_TYPE:  image_type_r  <= cfg_data[0];
        tga_rle_pkg::CFG_HAS_ALPHA:   has_alpha_r   <= cfg_data[0];
        tga_rle_pkg::CFG_PIXEL_COUNT: pixel_count_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_written_r   <= '0;
      packet_remaining_r <= '0;
      packet_is_run_r    <= 1'b0;
      expect_header_r    <= 1'b1;
      byte_slot_r        <= '0;
      gathered_r         <= '0;
      finished_r         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        pixels_written_r   <= pixels_written_nxt;
        packet_remaining_r <= packet_remaining_nxt;
        packet_is_run_r    <= packet_is_run_nxt;
        expect_header_r    <= expect_header_nxt;
        byte_slot_r        <= byte_slot_nxt;
        gathered_r         <= gathered_nxt;
        finished_r         <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      red_r         <= gathered_nxt[23:16];
      green_r       <= gathered_nxt[15:8];
      blue_r        <= gathered_nxt[7:0];
      alpha_r       <= alpha_val;
      start_index_r <= cur_pw;
      repeat_r      <= count;
      done_r        <= done_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = alpha_r;
  assign out_start_index = start_index_r;
  assign out_repeat_res  = repeat_r;
  assign out_image_done  = done_r;

  // a run in progress always has pixels left to place
  `ASSERT_ALWAYS(a_run_nonempty, !(packet_is_run_r && !expect_header_r) || (packet_remaining_r != '0), "run packet with zero remaining")
  // clipping never yields an empty result
  `ASSERT_ALWAYS(a_repeat_nonzero, !out_valid_r || (out_repeat_res != '0), "result with zero repeat")
  // the result that completes the image stops further decoding
  `ASSERT_NEXT(a_done_sets_finished, in_fire && emit && done_w, finished_r, "image done without finished")

endmodule
